### src/sbit_pkg.sv
// Package for the sorted breakpoint interpolation table.
// Holds the table size, field widths, item and result types, codes and sequencer states.
// No dependencies.
package sbit_pkg;

    localparam int DEPTH     = 16;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int VAL_W     = 16;
    localparam int INDEX_W   = 4;
    localparam int DIV_STEPS = 16;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    localparam logic signed [VAL_W-1:0] Q88_MINUS_ONE = -16'sd256;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_SET,
        KIND_EVAL,
        KIND_CLEAR
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK,
        ST_FULL,
        ST_EMPTY
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_MUL,
        S_PREP,
        S_DIV,
        S_FIX
    } t_state;

    typedef struct packed {
        t_kind                    kind;
        logic signed [VAL_W-1:0]  point_x;
        logic signed [VAL_W-1:0]  point_y;
    } t_item;

    typedef struct packed {
        logic signed [VAL_W-1:0]  value_out;
        logic [INDEX_W-1:0]       entry_index;
        t_status                  status;
    } t_result;

endpackage

### src/sorted_breakpoint_interpolation_table.sv
// Top level of the sorted breakpoint interpolation table.
// Depends on sbit_pkg for types, codes and sizes.
//
// The table holds up to DEPTH Q8.8 breakpoints sorted by x in a memory with one write port and
// one registered read port. Every beat on start is taken while busy is low and produces exactly
// one result beat on o_strobe, one cycle wide, which the receiver must take as it comes. A clear,
// or an evaluate on an empty table, is answered straight from idle, in the cycle after the beat.
// Other items scan the memory with a read state and a check state per entry up to the first x
// not below the item's x; an insert then moves each later entry up with a read state and a write
// state per entry, and an evaluate between two breakpoints adds one multiply, one setup and a
// sixteen-step shift-subtract divide, all in one shared datapath, with busy high the whole time.
module sorted_breakpoint_interpolation_table (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            start,
    output logic            busy,
    input  sbit_pkg::t_item i_item,
    output logic            o_strobe,
    output sbit_pkg::t_result o_result
);
    import sbit_pkg::*;

    t_state r_state, n_state;
    logic [CNT_W-1:0] r_cnt;
    logic r_strobe;
    t_result r_res, n_res;
    logic emit;

    logic signed [VAL_W-1:0] r_mem_x [DEPTH];
    logic signed [VAL_W-1:0] r_mem_y [DEPTH];
    logic signed [VAL_W-1:0] r_rd_x, r_rd_y;
    logic mem_we;
    logic [IDX_W-1:0] mem_waddr, rd_addr;
    logic signed [VAL_W-1:0] mem_wx, mem_wy;

    t_kind r_kind;
    logic signed [VAL_W-1:0] r_px, r_py, r_prev_x, r_prev_y;
    logic [CNT_W-1:0] r_idx, r_pos;
    logic signed [VAL_W:0] r_dy, r_dt;
    logic [VAL_W-1:0] r_dx;
    logic signed [2*VAL_W+1:0] r_prod;
    logic r_neg;
    logic [VAL_W:0] r_rem;
    logic [VAL_W-1:0] r_quo;
    logic [STEP_W-1:0] r_step;

    logic scan_end, is_eval, full, x_lt, x_eq, shift_last;
    logic [CNT_W-1:0] idx_dec;
    logic signed [VAL_W:0] y_sum;
    logic signed [VAL_W-1:0] y_avg, y_new, fix_val;
    logic signed [2*VAL_W+1:0] prod_mag;
    logic [VAL_W+2:0] trial;
    logic signed [VAL_W:0] q_signed;

    assign scan_end   = (r_idx == r_cnt);
    assign is_eval    = (r_kind == KIND_EVAL);
    assign full       = (r_cnt == CNT_W'(DEPTH));
    assign x_lt       = (r_rd_x < r_px);
    assign x_eq       = (r_rd_x == r_px);
    assign idx_dec    = r_idx - 1'b1;
    assign shift_last = (idx_dec == r_pos);
    assign y_sum      = 17'(r_rd_y) + 17'(r_py);
    assign y_avg      = y_sum[VAL_W:1];
    assign y_new      = (r_kind == KIND_ADD) ? y_avg : r_py;
    assign prod_mag   = r_prod[2*VAL_W+1] ? -r_prod : r_prod;
    assign trial      = {1'b0, r_rem, r_quo[VAL_W-1]} - {3'b000, r_dx};
    assign q_signed   = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign fix_val    = VAL_W'(17'(r_prev_y) + q_signed);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_item.kind == KIND_CLEAR) begin
                        n_state = S_IDLE;
                    end else if (i_item.kind == KIND_EVAL && r_cnt == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_SCAN_RD;
                    end
                end
            end
            S_SCAN_RD: begin
                if (!scan_end) begin
                    n_state = S_SCAN_CHK;
                end else if (is_eval || full) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_INSERT;
                end
            end
            S_SCAN_CHK: begin
                if (x_lt) begin
                    n_state = S_SCAN_RD;
                end else if (x_eq) begin
                    n_state = S_IDLE;
                end else if (is_eval) begin
                    n_state = (r_idx == '0) ? S_IDLE : S_MUL;
                end else if (full) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: n_state = shift_last ? S_INSERT : S_SHIFT_RD;
            S_INSERT:   n_state = S_IDLE;
            S_MUL:      n_state = S_PREP;
            S_PREP:     n_state = S_DIV;
            S_DIV:      n_state = (r_step == STEP_W'(DIV_STEPS - 1)) ? S_FIX : S_DIV;
            S_FIX:      n_state = S_IDLE;
            default:    n_state = S_IDLE;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_idx[IDX_W-1:0];
        mem_wx    = r_px;
        mem_wy    = y_new;
        rd_addr   = r_idx[IDX_W-1:0];
        emit      = 1'b0;
        n_res     = '{value_out: '0, entry_index: '0, status: ST_OK};
        case (r_state)
            S_IDLE: begin
                if (start && i_item.kind == KIND_CLEAR) begin
                    emit = 1'b1;
                end else if (start && i_item.kind == KIND_EVAL && r_cnt == '0) begin
                    emit = 1'b1;
                    n_res.value_out = Q88_MINUS_ONE;
                    n_res.status    = ST_EMPTY;
                end
            end
            S_SCAN_RD: begin
                if (scan_end && is_eval) begin
                    emit = 1'b1;
                    n_res.value_out = r_prev_y;
                end else if (scan_end && full) begin
                    emit = 1'b1;
                    n_res.status = ST_FULL;
                end
            end
            S_SCAN_CHK: begin
                if (!x_lt && x_eq) begin
                    emit = 1'b1;
                    if (is_eval) begin
                        n_res.value_out = r_rd_y;
                    end else begin
                        mem_we = 1'b1;
                        n_res.value_out   = y_new;
                        n_res.entry_index = INDEX_W'(r_idx);
                    end
                end else if (!x_lt && is_eval && r_idx == '0) begin
                    emit = 1'b1;
                    n_res.value_out = r_rd_y;
                end else if (!x_lt && !is_eval && full) begin
                    emit = 1'b1;
                    n_res.status = ST_FULL;
                end
            end
            S_SHIFT_RD: begin
                rd_addr = idx_dec[IDX_W-1:0];
            end
            S_SHIFT_WR: begin
                mem_we = 1'b1;
                mem_wx = r_rd_x;
                mem_wy = r_rd_y;
            end
            S_INSERT: begin
                mem_we    = 1'b1;
                mem_waddr = r_pos[IDX_W-1:0];
                mem_wy    = r_py;
                emit      = 1'b1;
                n_res.value_out   = r_py;
                n_res.entry_index = INDEX_W'(r_pos);
            end
            S_FIX: begin
                emit = 1'b1;
                n_res.value_out = fix_val;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= emit;
            if (r_state == S_IDLE && start && i_item.kind == KIND_CLEAR) begin
                r_cnt <= '0;
            end else if (r_state == S_INSERT) begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem_x[mem_waddr] <= mem_wx;
            r_mem_y[mem_waddr] <= mem_wy;
        end
        r_rd_x <= r_mem_x[rd_addr];
        r_rd_y <= r_mem_y[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_res <= n_res;
        end
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    r_kind <= i_item.kind;
                    r_px   <= i_item.point_x;
                    r_py   <= i_item.point_y;
                    r_idx  <= '0;
                end
            end
            S_SCAN_RD: begin
                if (scan_end) begin
                    r_pos <= r_idx;
                end
            end
            S_SCAN_CHK: begin
                if (x_lt) begin
                    r_prev_x <= r_rd_x;
                    r_prev_y <= r_rd_y;
                    r_idx    <= r_idx + 1'b1;
                end else if (!x_eq) begin
                    r_pos <= r_idx;
                    r_idx <= r_cnt;
                    r_dy  <= 17'(r_rd_y) - 17'(r_prev_y);
                    r_dt  <= 17'(r_px) - 17'(r_prev_x);
                    r_dx  <= VAL_W'(r_rd_x - r_prev_x);
                end
            end
            S_SHIFT_WR: begin
                r_idx <= idx_dec;
            end
            S_MUL: begin
                r_prod <= r_dy * r_dt;
            end
            S_PREP: begin
                r_neg  <= r_prod[2*VAL_W+1];
                r_rem  <= prod_mag[2*VAL_W:VAL_W];
                r_quo  <= prod_mag[VAL_W-1:0];
                r_step <= '0;
            end
            S_DIV: begin
                if (!trial[VAL_W+2]) begin
                    r_rem <= trial[VAL_W:0];
                    r_quo <= {r_quo[VAL_W-2:0], 1'b1};
                end else begin
                    r_rem <= {r_rem[VAL_W-1:0], r_quo[VAL_W-1]};
                    r_quo <= {r_quo[VAL_W-2:0], 1'b0};
                end
                r_step <= r_step + 1'b1;
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_res;

`ifndef SYNTH
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("breakpoint count above table size");

    a_one_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_strobe || busy))
        else $error("accepted beat neither answered nor in progress");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_FULL) |-> full)
        else $error("full status while the table has room");

    a_empty_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status == ST_EMPTY) |->
        (r_cnt == '0 && o_result.value_out == Q88_MINUS_ONE))
        else $error("empty status with entries present or wrong value");

    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < {1'b0, r_dx}))
        else $error("divider remainder not below divisor");
`endif

endmodule
